### src/brfo_pkg.sv
// ----------------------------------------------------------------------------
// brfo_pkg
// Shared types, widths and codes for the byte ring FIFO with overwrite.
// ----------------------------------------------------------------------------
package brfo_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int BYTE_W = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam cnt_t CNT_ONE   = cnt_t'(1);
  localparam cnt_t RING_MIN  = cnt_t'(2);
  localparam cnt_t RING_MAX  = cnt_t'(DEPTH);

  // Register indexes (word address bit)
  localparam logic REG_OVERWRITE = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  // Operation codes
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic overwrite;  // push into a full ring replaces the oldest byte
    cnt_t ring_size;  // clamped ring size, 2..DEPTH
    logic clear;      // capacity written this cycle: empty the ring
  } cfg_t;

endpackage

### src/brfo_store.sv
// ----------------------------------------------------------------------------
// brfo_store
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brfo_store (
  input  logic                 clk,
  input  logic                 we,
  input  brfo_pkg::ptr_t       waddr,
  input  brfo_pkg::byte_t      wdata,
  input  logic                 re,
  input  brfo_pkg::ptr_t       raddr,
  output brfo_pkg::byte_t      rdata
);

  brfo_pkg::byte_t mem [brfo_pkg::DEPTH];
  brfo_pkg::byte_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/brfo_regs.sv
// ----------------------------------------------------------------------------
// brfo_regs
// APB-style register port: overwrite mode and ring capacity.
// ----------------------------------------------------------------------------
module brfo_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brfo_pkg::ADDR_W-1:0]   paddr,
  input  logic [brfo_pkg::DATA_W-1:0]   pwdata,
  output logic [brfo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output brfo_pkg::cfg_t                cfg
);

  logic           overwrite_r;
  brfo_pkg::cnt_t cap_raw_r;
  brfo_pkg::cnt_t ring_size_r;
  brfo_pkg::cnt_t cap_wr;
  brfo_pkg::cnt_t cap_clamped;
  logic           wr_beat;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign cap_wr  = pwdata[brfo_pkg::CNT_W-1:0];

  // Clamp capacity to the legal ring range
  always_comb begin
    if (cap_wr < brfo_pkg::RING_MIN) begin
      cap_clamped = brfo_pkg::RING_MIN;
    end else if (cap_wr > brfo_pkg::RING_MAX) begin
      cap_clamped = brfo_pkg::RING_MAX;
    end else begin
      cap_clamped = cap_wr;
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overwrite_r <= 1'b0;
      cap_raw_r   <= brfo_pkg::RING_MAX;
      ring_size_r <= brfo_pkg::RING_MAX;
    end else if (wr_beat) begin
      case (reg_sel)
        brfo_pkg::REG_OVERWRITE: overwrite_r <= pwdata[0];
        brfo_pkg::REG_CAPACITY: begin
          cap_raw_r   <= cap_wr;
          ring_size_r <= cap_clamped;
        end
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      brfo_pkg::REG_OVERWRITE: prdata = brfo_pkg::DATA_W'(overwrite_r);
      brfo_pkg::REG_CAPACITY:  prdata = brfo_pkg::DATA_W'(cap_raw_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.overwrite = overwrite_r;
  assign cfg.ring_size = ring_size_r;
  assign cfg.clear     = wr_beat && (reg_sel == brfo_pkg::REG_CAPACITY);

endmodule

### src/byte_ring_fifo_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite
// Byte FIFO on a circular store with drop-or-overwrite on full.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/in_kind/in_push_byte/in_count and are taken at a
//   clock edge with start high and busy low. Results leave on out_valid with
//   out_byte, out_byte_valid, out_last, out_status and out_fill_level, one
//   beat per cycle; the receiver cannot stall, so every beat must be taken.
//   Push, flush and every status-only result: one beat, in the cycle after the
//   command is taken; the next command may follow in the very next cycle.
//   Pop and frame drain of n bytes: n beats on consecutive cycles, the first
//   in the cycle after the command; busy is high while further bytes remain
//   to be read, and the next command is taken once busy is low. The byte rate
//   is set by the single read port of the store: one byte read per cycle.
//   Registers sit on the APB-style port (overwrite mode at 0x0, ring capacity
//   at 0x4); the user must write them only while no command is in flight, as
//   the block does not enforce it. Writing the capacity empties the ring.
//   Reset (rst_n low, synchronous) empties the ring, clears overwrite mode
//   and sets the capacity to the full store; the store contents are left as
//   they are and are never read before being written.
// ----------------------------------------------------------------------------
module byte_ring_fifo_overwrite (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  brfo_pkg::byte_t               in_push_byte,
  input  brfo_pkg::cnt_t                in_count,
  // result channel
  output logic                          out_valid,
  output brfo_pkg::byte_t               out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic [1:0]                    out_status,
  output brfo_pkg::cnt_t                out_fill_level,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brfo_pkg::ADDR_W-1:0]   paddr,
  input  logic [brfo_pkg::DATA_W-1:0]   pwdata,
  output logic [brfo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  brfo_pkg::ptr_t  rd_ptr_r, rd_ptr_nxt;
  brfo_pkg::ptr_t  wr_ptr_r, wr_ptr_nxt;
  brfo_pkg::cnt_t  fill_r, fill_nxt;
  brfo_pkg::cnt_t  remain_r, remain_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_bv_r, out_bv_nxt;
  logic            out_last_r, out_last_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  brfo_pkg::cnt_t  out_fill_r, out_fill_nxt;

  brfo_pkg::cfg_t  cfg;
  brfo_pkg::byte_t ram_rdata;
  brfo_pkg::ptr_t  rd_adv, wr_adv;
  brfo_pkg::cnt_t  pop_len, stream_len;
  logic            accept, full, ram_we;
  logic            stream_go, issue, issue_last;

  // Pointer step with wrap at the ring size
  function automatic brfo_pkg::ptr_t ptr_step(input brfo_pkg::ptr_t p,
                                              input brfo_pkg::cnt_t size);
    brfo_pkg::cnt_t n;
    n = brfo_pkg::cnt_t'(p) + brfo_pkg::CNT_ONE;
    ptr_step = (n >= size) ? '0 : brfo_pkg::ptr_t'(n);
  endfunction

  brfo_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brfo_store u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_push_byte),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign busy    = (state_r == S_POP);
  assign accept  = start && !busy;
  assign full    = (fill_r == cfg.ring_size);
  assign rd_adv  = ptr_step(rd_ptr_r, cfg.ring_size);
  assign wr_adv  = ptr_step(wr_ptr_r, cfg.ring_size);
  assign pop_len = (in_count < fill_r) ? in_count : fill_r;

  // Command decode and byte streaming
  always_comb begin
    state_nxt      = state_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    remain_nxt     = remain_r;
    ram_we         = 1'b0;
    stream_go      = 1'b0;
    stream_len     = in_count;
    issue          = 1'b0;
    issue_last     = 1'b0;
    out_valid_nxt  = 1'b0;
    out_bv_nxt     = 1'b0;
    out_last_nxt   = 1'b1;
    out_status_nxt = brfo_pkg::ST_OK;
    out_fill_nxt   = fill_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_kind)
            brfo_pkg::KIND_PUSH: begin
              if (full && !cfg.overwrite) begin
                out_status_nxt = brfo_pkg::ST_DROPPED;
              end else begin
                ram_we     = 1'b1;
                wr_ptr_nxt = wr_adv;
                if (full) begin
                  rd_ptr_nxt = wr_adv;
                end else begin
                  fill_nxt = fill_r + brfo_pkg::CNT_ONE;
                end
                out_fill_nxt = fill_nxt;
              end
            end
            brfo_pkg::KIND_POP: begin
              if (fill_r == '0) begin
                out_status_nxt = brfo_pkg::ST_EMPTY;
              end else if (pop_len != '0) begin
                stream_go  = 1'b1;
                stream_len = pop_len;
              end
            end
            brfo_pkg::KIND_DRAIN: begin
              if (in_count > fill_r) begin
                out_status_nxt = brfo_pkg::ST_NOT_READY;
              end else if (in_count != '0) begin
                stream_go  = 1'b1;
                stream_len = in_count;
              end
            end
            brfo_pkg::KIND_FLUSH: begin
              rd_ptr_nxt   = wr_ptr_r;
              fill_nxt     = '0;
              out_fill_nxt = '0;
            end
            default: ;
          endcase

          // first byte of a pop or drain goes out with the command
          if (stream_go) begin
            issue      = 1'b1;
            issue_last = (stream_len == brfo_pkg::CNT_ONE);
            remain_nxt = stream_len - brfo_pkg::CNT_ONE;
            state_nxt  = issue_last ? S_IDLE : S_POP;
          end
        end
      end
      S_POP: begin
        issue      = 1'b1;
        issue_last = (remain_r == brfo_pkg::CNT_ONE);
        remain_nxt = remain_r - brfo_pkg::CNT_ONE;
        if (issue_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // one byte read: advance read side, report the level after removal
    if (issue) begin
      rd_ptr_nxt    = rd_adv;
      fill_nxt      = fill_r - brfo_pkg::CNT_ONE;
      out_valid_nxt = 1'b1;
      out_bv_nxt    = 1'b1;
      out_last_nxt  = issue_last;
      out_fill_nxt  = fill_nxt;
    end

    // capacity write empties the ring
    if (cfg.clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      fill_nxt   = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_bv_r     <= out_bv_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_bv_r ? ram_rdata : '0;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;
  assign out_fill_level = out_fill_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cfg.ring_size)
    else $error("fill level above ring size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (brfo_pkg::cnt_t'(rd_ptr_r) < cfg.ring_size) &&
    (brfo_pkg::cnt_t'(wr_ptr_r) < cfg.ring_size))
    else $error("pointer outside ring");

  a_cmd_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("command gave no result beat");

  a_stream_beat: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && out_byte_valid))
    else $error("byte stream stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_last)
    else $error("status beat not marked last");

endmodule
